### rtl/u2u8_pkg.sv
// Shared types, constants and UTF-8 encoding helpers for the UTF-16 to UTF-8 converter.
package u2u8_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int BURST_MAX       = 7;

  localparam logic [15:0] CAP_RESET   = 16'hFFFF;
  localparam logic [15:0] SUR_HIGH_LO = 16'hD800;
  localparam logic [15:0] SUR_HIGH_HI = 16'hDBFF;
  localparam logic [15:0] SUR_LOW_LO  = 16'hDC00;
  localparam logic [15:0] SUR_LOW_HI  = 16'hDFFF;
  localparam logic [20:0] REPLACEMENT = 21'h00FFFD;
  localparam logic [20:0] SUPP_BASE   = 21'h010000;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
  } out_item_t;

  typedef logic [3:0][7:0] char_bytes_t;

  // Bytes for one request, terminator included when present.
  typedef struct packed {
    logic [BURST_MAX-1:0][7:0] bytes;
    logic [2:0]                count;
    logic                      term;
  } burst_t;

  function automatic logic [2:0] char_len(input logic [20:0] cp);
    logic [2:0] n;
    if (cp < 21'h80) begin
      n = 3'd1;
    end else if (cp < 21'h800) begin
      n = 3'd2;
    end else if (cp < 21'h10000) begin
      n = 3'd3;
    end else begin
      n = 3'd4;
    end
    return n;
  endfunction

  function automatic char_bytes_t char_bytes(input logic [20:0] cp);
    char_bytes_t b;
    b = '0;
    unique case (char_len(cp))
      3'd1: begin
        b[0] = cp[7:0];
      end
      3'd2: begin
        b[0] = 8'hC0 | {3'b000, cp[10:6]};
        b[1] = 8'h80 | {2'b00, cp[5:0]};
      end
      3'd3: begin
        b[0] = 8'hE0 | {4'b0000, cp[15:12]};
        b[1] = 8'h80 | {2'b00, cp[11:6]};
        b[2] = 8'h80 | {2'b00, cp[5:0]};
      end
      default: begin
        b[0] = 8'hF0 | {5'b00000, cp[20:18]};
        b[1] = 8'h80 | {2'b00, cp[17:12]};
        b[2] = 8'h80 | {2'b00, cp[11:6]};
        b[3] = 8'h80 | {2'b00, cp[5:0]};
      end
    endcase
    return b;
  endfunction

endpackage

### rtl/u2u8_encoder.sv
// Input register, string state and per-unit transcoding into a byte burst.
module u2u8_encoder
  import u2u8_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  input  logic        cfg_valid,
  input  logic [15:0] cfg_data,
  output logic        burst_valid,
  input  logic        burst_ready,
  output burst_t      burst
);

  localparam int SW = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 1;
  localparam logic [SW-1:0] MAX_COUNT = SW'((64'd1 << COUNT_WIDTH) - 64'd1);

  logic                   held_valid;
  in_item_t               held;
  logic [15:0]            out_capacity;
  logic [9:0]             pending_high;
  logic                   pending_valid;
  logic [COUNT_WIDTH-1:0] bytes_used;
  logic                   halted;

  logic [9:0]             pending_high_next;
  logic                   pending_valid_next;
  logic [COUNT_WIDTH-1:0] bytes_used_next;
  logic                   halted_next;

  logic        consume;
  logic        is_high, is_low, fresh;
  logic [20:0] cp1, cp2;
  logic [2:0]  n1, n2, k1, k2, j;
  logic        req1, req2, e1, e2, halt1, halt2, zero_halt;
  logic [SW-1:0] cap, used0, used1, used2;
  char_bytes_t b1, b2;

  assign consume  = held_valid && burst_ready;
  assign in_ready = !held_valid || consume;

  always_comb begin
    cap = (SW'(out_capacity) < MAX_COUNT) ? SW'(out_capacity) : MAX_COUNT;
    is_high = (held.code_unit >= SUR_HIGH_LO) && (held.code_unit <= SUR_HIGH_HI);
    is_low  = (held.code_unit >= SUR_LOW_LO) && (held.code_unit <= SUR_LOW_HI);
    used0   = SW'(bytes_used);

    // first character: the waiting high surrogate, paired or replaced
    req1  = !halted && pending_valid;
    cp1   = is_low ? (SUPP_BASE + {1'b0, pending_high, held.code_unit[9:0]}) : REPLACEMENT;
    n1    = char_len(cp1);
    b1    = char_bytes(cp1);
    e1    = req1 && ((used0 + SW'(n1)) < cap);
    halt1 = req1 && !e1;
    k1    = e1 ? n1 : 3'd0;
    used1 = used0 + SW'(k1);
    fresh = !(pending_valid && is_low);

    // second character: the unit on its own
    zero_halt = !halted && !halt1 && fresh && (held.code_unit == 16'h0000);
    req2 = !halted && !halt1 && fresh && (held.code_unit != 16'h0000)
           && !(is_high && !held.last);
    cp2  = (is_high || is_low) ? REPLACEMENT : {5'b00000, held.code_unit};
    n2   = char_len(cp2);
    b2   = char_bytes(cp2);
    e2    = req2 && ((used1 + SW'(n2)) < cap);
    halt2 = req2 && !e2;
    k2    = e2 ? n2 : 3'd0;
    used2 = used1 + SW'(k2);

    pending_valid_next = !halted && !halt1 && fresh && is_high && !held.last;
    pending_high_next  = held.code_unit[9:0];
    halted_next        = halted || halt1 || halt2 || zero_halt;
    bytes_used_next    = used2[COUNT_WIDTH-1:0];
    if (held.last) begin
      pending_valid_next = 1'b0;
      pending_high_next  = '0;
      halted_next        = 1'b0;
      bytes_used_next    = '0;
    end

    // pack both characters, then the terminator
    for (int i = 0; i < BURST_MAX; i++) begin
      j = 3'(i) - k1;
      if (3'(i) < k1) begin
        burst.bytes[i] = b1[2'(i)];
      end else if (j < k2) begin
        burst.bytes[i] = b2[j[1:0]];
      end else begin
        burst.bytes[i] = 8'h00;
      end
    end
    burst.count = k1 + k2 + {2'b00, held.last};
    burst.term  = held.last;
  end

  assign burst_valid = held_valid && (burst.count != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid    <= 1'b0;
      out_capacity  <= CAP_RESET;
      pending_high  <= '0;
      pending_valid <= 1'b0;
      bytes_used    <= '0;
      halted        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        out_capacity <= cfg_data;
      end
      if (consume) begin
        pending_high  <= pending_high_next;
        pending_valid <= pending_valid_next;
        bytes_used    <= bytes_used_next;
        halted        <= halted_next;
      end
      if (in_valid && in_ready) begin
        held_valid <= 1'b1;
      end else if (consume) begin
        held_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held <= in_item;
    end
  end

endmodule

### rtl/u2u8_serializer.sv
// Byte burst buffer that drives the output channel one byte per cycle while out_ready is high.
module u2u8_serializer
  import u2u8_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      burst_valid,
  output logic      burst_ready,
  input  burst_t    burst,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic                      buf_valid;
  logic [BURST_MAX-1:0][7:0] bytes;
  logic [2:0]                count;
  logic [2:0]                idx;
  logic                      term;
  logic                      take, at_end;

  assign take        = buf_valid && out_ready;
  assign at_end      = (idx == (count - 3'd1));
  assign burst_ready = !buf_valid || (take && at_end);

  assign out_valid           = buf_valid;
  assign out_item.out_byte   = bytes[idx];
  assign out_item.run_last   = at_end;
  assign out_item.string_end = at_end && term;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      idx       <= '0;
    end else if (burst_valid && burst_ready) begin
      buf_valid <= 1'b1;
      idx       <= '0;
    end else if (take) begin
      if (at_end) begin
        buf_valid <= 1'b0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (burst_valid && burst_ready) begin
      bytes <= burst.bytes;
      count <= burst.count;
      term  <= burst.term;
    end
  end

endmodule

### rtl/utf16_to_utf8_converter.sv
// Top level: UTF-16 code units in, UTF-8 bytes out, with bounded output capacity.
// A request is taken into the input register, transcoded, and loaded into the output
// buffer once that buffer is free, where its first byte is offered.
// Each request yields N bytes (0 to 7) on the single-byte output port; the input
// register takes the next request while the output buffer drains the last one.
// Reset (rst, synchronous): clear pending surrogate, byte count, halt flag and both
// stages; out_capacity returns to 65535.
module utf16_to_utf8_converter
  import u2u8_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  // Burst handoff between the transcoder and the output buffer.
  logic   burst_valid;
  logic   burst_ready;
  burst_t burst;

  // Capacity writes land in the next cycle; always take them.
  assign cfg_ready = 1'b1;

  // Hold one code unit, track surrogate and capacity state, and build the
  // bytes for each request in a single pass.
  u2u8_encoder #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_encoder (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .burst_valid(burst_valid),
    .burst_ready(burst_ready),
    .burst      (burst)
  );

  // Drain the burst one byte per cycle while out_ready is high; accept the
  // next burst as the last byte leaves, so requests flow without bubbles.
  u2u8_serializer u_serializer (
    .clk        (clk),
    .rst        (rst),
    .burst_valid(burst_valid),
    .burst_ready(burst_ready),
    .burst      (burst),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

  // The terminator is always the final byte of its request.
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.string_end |-> out_item.run_last)
    else $error("string_end without run_last");

  // An empty burst must never be handed to the output buffer.
  a_burst_nonempty: assert property (@(posedge clk) disable iff (rst)
    burst_valid && burst_ready |-> (burst.count != 3'd0))
    else $error("empty burst handed off");

  // Both stages come out of reset empty, so input is taken at once.
  a_ready_after_reset: assert property (@(posedge clk)
    $past(rst) |-> (in_ready && !out_valid))
    else $error("not ready after reset");

endmodule
